>>> src/tsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsv_pkg - timestamp text validator shared definitions
// Status codes, the record handed from the character scanner to the checker,
// and the month length table.
// ----------------------------------------------------------------------------
package tsv_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_GRAMMAR  = 2'd2,
		ST_CALENDAR = 2'd3
	} status_t;

	// Layout positions of interest
	localparam logic [4:0] LAST_POS_NATIVE = 5'd22;
	localparam logic [4:0] LAST_POS_DASHED = 5'd23;
	localparam logic [4:0] POS_MAX         = 5'd31;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_Z     = 8'h5A;

	// Range limits
	localparam logic [6:0] MONTH_MAX  = 7'd12;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;
	localparam logic [6:0] FEB        = 7'd2;

	// One finished timestamp, as scanned
	typedef struct packed {
		logic        length_bad;
		logic        early_bad;
		logic [3:0]  time_bad;
		logic        leap;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [9:0]  milli;
	} rec_t;

	// Days in a month for a common year; codes outside 1..12 give zero
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                        d = 5'd28;
			default:                                     d = 5'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

>>> src/tsv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsv_if - timestamp text validator channels
// Character input, result output and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface tsv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface tsv_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [13:0] year_value;
	logic [6:0]  month_value;
	logic [6:0]  day_value;
	logic [6:0]  hour_value;
	logic [6:0]  minute_value;
	logic [6:0]  second_value;
	logic [9:0]  milli_value;

	modport source (output valid, output status, output year_value, output month_value,
		output day_value, output hour_value, output minute_value, output second_value,
		output milli_value, input ready);
	modport sink   (input valid, input status, input year_value, input month_value,
		input day_value, input hour_value, input minute_value, input second_value,
		input milli_value, output ready);
endinterface

interface tsv_cfg_if;
	logic valid;
	logic ready;
	logic native_format;

	modport source (output valid, output native_format, input ready);
	modport sink   (input valid, input native_format, output ready);
endinterface
`default_nettype wire

>>> src/tsv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsv_front - character scanner
// Walks the fixed layout one character a cycle unless the queue is full,
// accumulates numeric fields and error flags, pushes one record per timestamp.
// ----------------------------------------------------------------------------
module tsv_front
	import tsv_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	tsv_char_if.sink in_ch,
	tsv_cfg_if.sink  cfg_ch,
	input  wire  q_full,
	output logic push,
	output rec_t push_rec
);

	logic        native_q;
	logic [4:0]  pos_q;
	logic        early_q;
	logic [3:0]  tbad_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
	logic [9:0]  milli_q;
	logic [6:0]  cent_q;
	logic        lo_zero_q;

	logic        early_n;
	logic [3:0]  tbad_n;
	logic [13:0] year_n;
	logic [6:0]  month_n, day_n, hour_n, minute_n, second_n;
	logic [9:0]  milli_n;
	logic [6:0]  cent_n;
	logic        lo_zero_n;

	logic        is_digit;
	logic [3:0]  dval;
	logic [7:0]  sep;
	logic        accept;

	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !q_full;
	assign cfg_ch.ready = 1'b1;

	assign is_digit = (in_ch.char_code >= CH_ZERO) && (in_ch.char_code <= CH_NINE);
	assign dval     = 4'(in_ch.char_code - CH_ZERO);
	assign sep      = native_q ? CH_DOT : CH_DASH;

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q <= 1'b0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			native_q <= cfg_ch.native_format;
		end
	end

	// Classify the character by position and update fields
	always_comb begin
		early_n   = early_q;
		tbad_n    = tbad_q;
		year_n    = year_q;
		month_n   = month_q;
		day_n     = day_q;
		hour_n    = hour_q;
		minute_n  = minute_q;
		second_n  = second_q;
		milli_n   = milli_q;
		cent_n    = cent_q;
		lo_zero_n = lo_zero_q;
		case (pos_q) inside
			[5'd0:5'd3]: begin
				if (is_digit) begin
					year_n = 14'((18'(year_q) * 18'd10) + 18'(dval));
				end else begin
					early_n = 1'b1;
				end
				if (pos_q == 5'd1) begin
					cent_n = year_n[6:0];
				end
				if (pos_q == 5'd2) begin
					lo_zero_n = (in_ch.char_code == CH_ZERO);
				end
				if (pos_q == 5'd3) begin
					lo_zero_n = lo_zero_q && (in_ch.char_code == CH_ZERO);
				end
			end
			5'd5, 5'd6: begin
				if (is_digit) month_n = 7'((11'(month_q) * 11'd10) + 11'(dval));
				else early_n = 1'b1;
			end
			5'd8, 5'd9: begin
				if (is_digit) day_n = 7'((11'(day_q) * 11'd10) + 11'(dval));
				else early_n = 1'b1;
			end
			5'd11, 5'd12: begin
				if (is_digit) hour_n = 7'((11'(hour_q) * 11'd10) + 11'(dval));
				else tbad_n[0] = 1'b1;
			end
			5'd14, 5'd15: begin
				if (is_digit) minute_n = 7'((11'(minute_q) * 11'd10) + 11'(dval));
				else tbad_n[1] = 1'b1;
			end
			5'd17, 5'd18: begin
				if (is_digit) second_n = 7'((11'(second_q) * 11'd10) + 11'(dval));
				else tbad_n[2] = 1'b1;
			end
			[5'd20:5'd22]: begin
				if (is_digit) milli_n = 10'((14'(milli_q) * 14'd10) + 14'(dval));
				else tbad_n[3] = 1'b1;
			end
			5'd4, 5'd7: begin
				if (in_ch.char_code != sep) early_n = 1'b1;
			end
			5'd10: begin
				if (in_ch.char_code != CH_SPACE) early_n = 1'b1;
			end
			5'd13, 5'd16: begin
				if (in_ch.char_code != CH_COLON) early_n = 1'b1;
			end
			5'd19: begin
				if (in_ch.char_code != CH_DOT) early_n = 1'b1;
			end
			5'd23: begin
				if (!native_q && (in_ch.char_code != CH_Z)) early_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Build the record for the last character
	always_comb begin
		push_rec.length_bad = (pos_q != (native_q ? LAST_POS_NATIVE : LAST_POS_DASHED));
		push_rec.early_bad  = early_n;
		push_rec.time_bad   = tbad_n;
		// divisible by 4, and not a century unless the century is divisible by 4
		push_rec.leap       = (year_n[1:0] == 2'b00) && (!lo_zero_n || (cent_n[1:0] == 2'b00));
		push_rec.year       = year_n;
		push_rec.month      = month_n;
		push_rec.day        = day_n;
		push_rec.hour       = hour_n;
		push_rec.minute     = minute_n;
		push_rec.second     = second_n;
		push_rec.milli      = milli_n;
	end

	assign push = accept && in_ch.is_last;

	// Advance the scan state; clear after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			early_q   <= 1'b0;
			tbad_q    <= '0;
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			milli_q   <= '0;
			cent_q    <= '0;
			lo_zero_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.is_last) begin
				pos_q     <= '0;
				early_q   <= 1'b0;
				tbad_q    <= '0;
				year_q    <= '0;
				month_q   <= '0;
				day_q     <= '0;
				hour_q    <= '0;
				minute_q  <= '0;
				second_q  <= '0;
				milli_q   <= '0;
				cent_q    <= '0;
				lo_zero_q <= 1'b0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 5'd1;
				early_q   <= early_n;
				tbad_q    <= tbad_n;
				year_q    <= year_n;
				month_q   <= month_n;
				day_q     <= day_n;
				hour_q    <= hour_n;
				minute_q  <= minute_n;
				second_q  <= second_n;
				milli_q   <= milli_n;
				cent_q    <= cent_n;
				lo_zero_q <= lo_zero_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/tsv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsv_queue - record queue
// Small FIFO of scanned records between the scanner and the checker.
// ----------------------------------------------------------------------------
module tsv_queue
	import tsv_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  rec_t push_rec,
	output logic full,
	input  wire  pop,
	output logic not_empty,
	output rec_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Store the pushed record
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

>>> src/tsv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsv_back - calendar checker
// Judges the record at the queue head in error priority order and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module tsv_back
	import tsv_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  not_empty,
	input  rec_t head,
	output logic pop,
	tsv_result_if.source out_ch
);

	logic        out_valid_q;
	status_t     status_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
	logic [9:0]  milli_q;

	status_t    st;
	logic [4:0] limit;
	logic       month_bad;

	// Day limit for the month, February stretched in leap years
	assign limit = month_days(head.month[3:0]) +
		5'((head.month == FEB) && head.leap);
	assign month_bad = (head.year == '0) || (head.month == '0) || (head.month > MONTH_MAX);

	// Pick the first failing check
	always_comb begin
		if (head.length_bad)                                  st = ST_LENGTH;
		else if (head.early_bad)                              st = ST_GRAMMAR;
		else if (month_bad)                                   st = ST_CALENDAR;
		else if ((head.day == '0) || (head.day > 7'(limit)))  st = ST_CALENDAR;
		else if (head.time_bad[0])                            st = ST_GRAMMAR;
		else if (head.hour > HOUR_MAX)                        st = ST_CALENDAR;
		else if (head.time_bad[1])                            st = ST_GRAMMAR;
		else if (head.minute > MINSEC_MAX)                    st = ST_CALENDAR;
		else if (head.time_bad[2])                            st = ST_GRAMMAR;
		else if (head.second > MINSEC_MAX)                    st = ST_CALENDAR;
		else if (head.time_bad[3])                            st = ST_GRAMMAR;
		else                                                  st = ST_VALID;
	end

	assign pop = not_empty && (!out_valid_q || out_ch.ready);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result fields; zero the values on any error
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= st;
			year_q   <= (st == ST_VALID) ? head.year   : '0;
			month_q  <= (st == ST_VALID) ? head.month  : '0;
			day_q    <= (st == ST_VALID) ? head.day    : '0;
			hour_q   <= (st == ST_VALID) ? head.hour   : '0;
			minute_q <= (st == ST_VALID) ? head.minute : '0;
			second_q <= (st == ST_VALID) ? head.second : '0;
			milli_q  <= (st == ST_VALID) ? head.milli  : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.year_value   = year_q;
	assign out_ch.month_value  = month_q;
	assign out_ch.day_value    = day_q;
	assign out_ch.hour_value   = hour_q;
	assign out_ch.minute_value = minute_q;
	assign out_ch.second_value = second_q;
	assign out_ch.milli_value  = milli_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_VALID)) |->
		((year_q == '0) && (month_q == '0) && (day_q == '0) && (milli_q == '0)))
		else $error("error result carries non-zero fields");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_VALID)) |->
		((month_q != '0) && (month_q <= MONTH_MAX) && (day_q != '0) &&
		 (hour_q <= HOUR_MAX) && (minute_q <= MINSEC_MAX) && (second_q <= MINSEC_MAX)))
		else $error("valid result out of calendar range");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped record not presented");
`endif

endmodule
`default_nettype wire

>>> src/timestamp_text_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_text_validator - fixed-layout timestamp text checker
// Scans one character per cycle while the queue has room and reports status
// and parsed fields for each timestamp after its last character.
// ----------------------------------------------------------------------------
// One character is accepted every cycle while the queue is not full. The scanner
// updates its field accumulators as each character arrives; on the last
// character it pushes a record into a QUEUE_DEPTH-entry queue, and the checker
// judges the queue head and registers the result in its output register. The
// input stalls only when the queue is full, that is when the result side has
// held back QUEUE_DEPTH + 1 results. The format register may be written at any
// time; its channel is always ready.
module timestamp_text_validator
	import tsv_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input wire clk,
	input wire arst_n,
	tsv_char_if.sink     in_ch,
	tsv_cfg_if.sink      cfg_ch,
	tsv_result_if.source out_ch
);

	logic push, pop, q_full, q_not_empty;
	rec_t push_rec, head;

	tsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg_ch   (cfg_ch),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	tsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	tsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
